// ===== hw/rtl/swf_pkg.sv =====
`default_nettype none
package swf_pkg;

  localparam int COORD_W = 32;
  localparam int NUM_IN = 4;
  localparam int DIMS_W = 3;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int MAX_DIMS_DEF = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  // token for the dominance scan: beaten = some entry dominates the point,
  // room = some slot is empty or about to be freed
  typedef struct packed {
    logic active;
    logic beaten;
    logic room;
  } scan_tok_t;

  // token for the insert sweep, pairs with a carried entry
  typedef struct packed {
    logic active;
    logic carry_valid;
  } merge_tok_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swf_cell.sv =====
`default_nettype none
module swf_cell #(
  parameter int WINDOW_DEPTH = 64,
  parameter int MAX_DIMS = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire swf_pkg::coord_t [MAX_DIMS-1:0]           pt,
  input  wire logic [MAX_DIMS-1:0]                     dim_use,
  input  wire logic                                    drain,
  input  wire logic                                    shift_in_valid,
  input  wire swf_pkg::coord_t [MAX_DIMS-1:0]           shift_in_entry,
  input  wire swf_pkg::scan_tok_t                      scan_in,
  input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]       removed_in,
  output swf_pkg::scan_tok_t                           scan_out,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]            removed_out,
  input  wire swf_pkg::merge_tok_t                     merge_in,
  input  wire swf_pkg::coord_t [MAX_DIMS-1:0]           carry_in,
  output swf_pkg::merge_tok_t                          merge_out,
  output swf_pkg::coord_t [MAX_DIMS-1:0]                carry_out,
  output logic                                         valid,
  output swf_pkg::coord_t [MAX_DIMS-1:0]                entry
);
  import swf_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic [MAX_DIMS-1:0] e_lt;
  logic [MAX_DIMS-1:0] e_gt;
  logic                dom_ep;  // stored entry dominates the point
  logic                dom_pe;  // point dominates the stored entry
  logic                doomed;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      e_lt[i] = dim_use[i] && ($signed(entry[i]) < $signed(pt[i]));
      e_gt[i] = dim_use[i] && ($signed(entry[i]) > $signed(pt[i]));
    end
    dom_ep = (e_gt == '0) && (e_lt != '0);
    dom_pe = (e_lt == '0) && (e_gt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      doomed    <= 1'b0;
      scan_out  <= '0;
      merge_out <= '0;
    end else begin
      scan_out.active  <= scan_in.active;
      scan_out.beaten  <= scan_in.beaten || (valid && dom_ep);
      scan_out.room    <= scan_in.room || !valid || dom_pe;
      merge_out.active <= merge_in.active;
      // a live entry is pushed one cell further; a free or doomed slot absorbs the carry
      merge_out.carry_valid <= !drain && !scan_in.active && merge_in.active &&
                               merge_in.carry_valid && valid && !doomed;
      if (drain) begin
        valid <= shift_in_valid;
      end else if (scan_in.active) begin
        doomed <= valid && dom_pe;
      end else if (merge_in.active) begin
        doomed <= 1'b0;
        if (merge_in.carry_valid) begin
          valid <= 1'b1;
        end else if (doomed) begin
          valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    removed_out <= removed_in + CNT_W'(valid && dom_pe);
    carry_out   <= entry;
    if (drain) begin
      entry <= shift_in_entry;
    end else if (merge_in.active && merge_in.carry_valid) begin
      entry <= carry_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/skyline_window_filter.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         start / busy              coord_a..coord_d, last_point
// result    out        result_valid (1 cycle)    out_a..out_d, final_result,
//                                                window_overflowed
// config    in         cfg_we                    cfg_data (dims_in_use)
//
// One point at a time. The window is a row of WINDOW_DEPTH cells, newest entry
// in cell 0. A dropped point takes one scan token walk down the row; a kept
// point takes the scan, then an insert sweep. A last point adds a drain while
// the row shifts toward cell 0. busy covers all of it. Reset empties the
// window and sets dims_in_use to 4. Results cannot be stalled by the receiver.
module skyline_window_filter #(
  parameter int WINDOW_DEPTH = swf_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_DIMS = swf_pkg::MAX_DIMS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire swf_pkg::coord_t             coord_a,
  input  wire swf_pkg::coord_t             coord_b,
  input  wire swf_pkg::coord_t             coord_c,
  input  wire swf_pkg::coord_t             coord_d,
  input  wire logic                        last_point,
  input  wire logic                        cfg_we,
  input  wire logic [swf_pkg::DIMS_W-1:0]  cfg_data,
  output logic                             result_valid,
  output swf_pkg::coord_t                  out_a,
  output swf_pkg::coord_t                  out_b,
  output swf_pkg::coord_t                  out_c,
  output swf_pkg::coord_t                  out_d,
  output logic                             final_result,
  output logic                             window_overflowed
);
  import swf_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_MERGE = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t                   state;
  logic                     scan_kick;
  logic                     merge_kick;
  logic [DIMS_W-1:0]        dims;
  logic                     overflow;
  logic [CNT_W-1:0]         count;
  logic                     last_flag;
  coord_t [MAX_DIMS-1:0]    pt;
  coord_t [MAX_DIMS-1:0]    pt_next;
  coord_t [NUM_IN-1:0]      in_pad;
  coord_t [NUM_IN-1:0]      out_pad;
  logic [MAX_DIMS-1:0]      dim_use;
  logic                     drain;
  logic                     accept;

  scan_tok_t                scan_chain    [WINDOW_DEPTH+1];
  logic [CNT_W-1:0]         removed_chain [WINDOW_DEPTH+1];
  merge_tok_t               merge_chain   [WINDOW_DEPTH+1];
  coord_t [MAX_DIMS-1:0]    carry_chain   [WINDOW_DEPTH+1];
  logic                     cell_valid    [WINDOW_DEPTH];
  coord_t [MAX_DIMS-1:0]    cell_entry    [WINDOW_DEPTH];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign drain  = (state == S_DRAIN);

  assign in_pad[0] = coord_a;
  assign in_pad[1] = coord_b;
  assign in_pad[2] = coord_c;
  assign in_pad[3] = coord_d;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
    assign dim_use[i] = (i < NUM_IN) && (DIMS_W'(i) < dims);
    if (i < NUM_IN) begin : g_in
      assign pt_next[i] = in_pad[i];
    end else begin : g_zero
      assign pt_next[i] = '0;
    end
  end

  for (genvar i = 0; i < NUM_IN; i++) begin : g_out
    if (i < MAX_DIMS) begin : g_take
      assign out_pad[i] = cell_entry[0][i];
    end else begin : g_zero
      assign out_pad[i] = '0;
    end
  end

  assign scan_chain[0]    = '{active: scan_kick, beaten: 1'b0, room: 1'b0};
  assign removed_chain[0] = '0;
  assign merge_chain[0]   = '{active: merge_kick, carry_valid: 1'b1};
  assign carry_chain[0]   = pt;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic                  sh_valid;
    coord_t [MAX_DIMS-1:0] sh_entry;

    if (k < WINDOW_DEPTH - 1) begin : g_mid
      assign sh_valid = cell_valid[k+1];
      assign sh_entry = cell_entry[k+1];
    end else begin : g_end
      assign sh_valid = 1'b0;
      assign sh_entry = '0;
    end

    swf_cell #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_DIMS     (MAX_DIMS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .pt             (pt),
      .dim_use        (dim_use),
      .drain          (drain),
      .shift_in_valid (sh_valid),
      .shift_in_entry (sh_entry),
      .scan_in        (scan_chain[k]),
      .removed_in     (removed_chain[k]),
      .scan_out       (scan_chain[k+1]),
      .removed_out    (removed_chain[k+1]),
      .merge_in       (merge_chain[k]),
      .carry_in       (carry_chain[k]),
      .merge_out      (merge_chain[k+1]),
      .carry_out      (carry_chain[k+1]),
      .valid          (cell_valid[k]),
      .entry          (cell_entry[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_kick    <= 1'b0;
      merge_kick   <= 1'b0;
      dims         <= DIMS_RESET;
      overflow     <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      scan_kick    <= accept;
      merge_kick   <= (state == S_SCAN) && scan_chain[WINDOW_DEPTH].active &&
                      !scan_chain[WINDOW_DEPTH].beaten && scan_chain[WINDOW_DEPTH].room;
      result_valid <= drain && (count != '0) && cell_valid[0];
      if (cfg_we) begin
        dims <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_chain[WINDOW_DEPTH].active) begin
            if (!scan_chain[WINDOW_DEPTH].beaten && scan_chain[WINDOW_DEPTH].room) begin
              count <= count - removed_chain[WINDOW_DEPTH] + CNT_W'(1);
              state <= S_MERGE;
            end else begin
              if (!scan_chain[WINDOW_DEPTH].beaten) begin
                overflow <= 1'b1;
              end
              state <= last_flag ? S_DRAIN : S_IDLE;
            end
          end
        end
        S_MERGE: begin
          if (merge_chain[WINDOW_DEPTH].active) begin
            state <= last_flag ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          // holes left by removals just shift past without a transaction
          if (count == '0) begin
            overflow <= 1'b0;
            state    <= S_IDLE;
          end else if (cell_valid[0]) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              overflow <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt        <= pt_next;
      last_flag <= last_point;
    end
    if (drain && cell_valid[0]) begin
      out_a             <= out_pad[0];
      out_b             <= out_pad[1];
      out_c             <= out_pad[2];
      out_d             <= out_pad[3];
      final_result      <= (count == CNT_W'(1));
      window_overflowed <= overflow;
    end
  end

endmodule
`default_nettype wire

// ===== dv/skyline_window_filter_checker.sv =====
module skyline_window_filter_checker #(
  parameter int WINDOW_DEPTH = swf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire swf_pkg::coord_t            coord_a,
  input  wire swf_pkg::coord_t            coord_b,
  input  wire swf_pkg::coord_t            coord_c,
  input  wire swf_pkg::coord_t            coord_d,
  input  wire logic                       last_point,
  input  wire logic                       cfg_we,
  input  wire logic [swf_pkg::DIMS_W-1:0] cfg_data,
  input  wire logic                       result_valid,
  input  wire swf_pkg::coord_t            out_a,
  input  wire swf_pkg::coord_t            out_b,
  input  wire swf_pkg::coord_t            out_c,
  input  wire swf_pkg::coord_t            out_d,
  input  wire logic                       final_result,
  input  wire logic                       window_overflowed,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked
);
  import swf_pkg::*;

  typedef logic [NUM_IN-1:0][COORD_W-1:0] point_t;

  typedef struct packed {
    point_t pt;
    logic   last;
    logic   ovf;
  } survivor_t;

  point_t            window [WINDOW_DEPTH];
  int                fill;
  logic              overflow_seen;
  logic [DIMS_W-1:0] dims_now;
  survivor_t         survivors_due [$];
  int                fails;
  int                results;

  // p beats q: no worse in every compared coordinate, strictly better in one
  function automatic logic beats(point_t p, point_t q, int d);
    logic strict;
    strict = 1'b0;
    for (int i = 0; i < d; i++) begin
      if ($signed(p[i]) > $signed(q[i])) return 1'b0;
      if ($signed(p[i]) < $signed(q[i])) strict = 1'b1;
    end
    return strict;
  endfunction

  task automatic admit_point(point_t pt, logic lp);
    int        d;
    int        keep;
    logic      beaten;
    survivor_t s;
    d = (dims_now > NUM_IN) ? NUM_IN : int'(dims_now);
    beaten = 1'b0;
    for (int i = 0; i < fill; i++) begin
      if (beats(window[i], pt, d)) beaten = 1'b1;
    end
    if (!beaten) begin
      keep = 0;
      for (int i = 0; i < fill; i++) begin
        if (!beats(pt, window[i], d)) begin
          window[keep] = window[i];
          keep++;
        end
      end
      fill = keep;
      // full check comes after pruning
      if (fill < WINDOW_DEPTH) begin
        window[fill] = pt;
        fill++;
      end else begin
        overflow_seen = 1'b1;
      end
    end
    if (lp) begin
      for (int i = 0; i < fill; i++) begin
        s.pt = window[fill-1-i];
        s.last = (i == fill - 1);
        s.ovf = overflow_seen;
        survivors_due.push_back(s);
      end
      fill = 0;
      overflow_seen = 1'b0;
    end
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] want,
                             logic [COORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    survivor_t want;
    if (rst) begin
      fill = 0;
      overflow_seen = 1'b0;
      dims_now = DIMS_RESET;
      survivors_due.delete();
      fails = 0;
      results = 0;
    end else begin
      if (result_valid) begin
        if (survivors_due.size() == 0) begin
          $display({"%0t: unexpected result: expected none, actual ",
                    "a=%0d b=%0d c=%0d d=%0d fin=%0d ovf=%0d"},
                   $time, out_a, out_b, out_c, out_d, final_result, window_overflowed);
          fails++;
        end else begin
          want = survivors_due.pop_front();
          check_field("out_a", want.pt[0], out_a);
          check_field("out_b", want.pt[1], out_b);
          check_field("out_c", want.pt[2], out_c);
          check_field("out_d", want.pt[3], out_d);
          check_field("final_result", COORD_W'(want.last), COORD_W'(final_result));
          check_field("window_overflowed", COORD_W'(want.ovf), COORD_W'(window_overflowed));
          results++;
        end
      end
      if (cfg_we) dims_now = cfg_data;
      if (start && !busy) admit_point({coord_d, coord_c, coord_b, coord_a}, last_point);
    end
    fail_count <= fails;
    pending <= survivors_due.size();
    results_checked <= results;
  end

endmodule

// ===== dv/skyline_window_filter_tb.sv =====
module skyline_window_filter_tb;
  import swf_pkg::*;

  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES = 2 * WINDOW_DEPTH_DEF + 3 + WINDOW_DEPTH_DEF + 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  coord_t            coord_a, coord_b, coord_c, coord_d;
  logic              last_point;
  logic              cfg_we;
  logic [DIMS_W-1:0] cfg_data;
  logic              result_valid;
  coord_t            out_a, out_b, out_c, out_d;
  logic              final_result;
  logic              window_overflowed;

  int fail_count;
  int pending;
  int results_checked;
  int idle_pct;
  int points_sent;
  int sets_sent;

  logic [DIMS_W-1:0] dims_plan [8] = '{3'd2, 3'd1, 3'd3, 3'd0, 3'd7, 3'd4, 3'd5, 3'd6};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  skyline_window_filter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c), .coord_d(coord_d),
    .last_point(last_point), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d),
    .final_result(final_result), .window_overflowed(window_overflowed)
  );

  skyline_window_filter_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c), .coord_d(coord_d),
    .last_point(last_point), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d),
    .final_result(final_result), .window_overflowed(window_overflowed),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
  );

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return CMIN;
      1: return CMAX;
      2, 3: return coord_t'($urandom);
      // narrow range so dominance and ties are common
      default: return coord_t'(int'($urandom_range(6)) - 3);
    endcase
  endfunction

  // start stays high after acceptance so back-to-back points need no toggle
  task automatic send_point(coord_t a, coord_t b, coord_t c, coord_t d, logic lp);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    coord_a = a;
    coord_b = b;
    coord_c = c;
    coord_d = d;
    last_point = lp;
    @(posedge clk);
    while (busy) @(posedge clk);
    points_sent++;
    if (lp) sets_sent++;
  endtask

  task automatic send_random_set();
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == n - 1);
  endtask

  // hold off until every survivor has been emitted, then let the row settle
  task automatic drain_window();
    int waited;
    waited = 0;
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dims(logic [DIMS_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stim
    rst = 1'b1;
    start = 1'b0;
    coord_a = '0;
    coord_b = '0;
    coord_c = '0;
    coord_d = '0;
    last_point = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    points_sent = 0;
    sets_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // all four coordinates in use after reset
    send_point(0, 0, 0, 0, 1'b0);
    send_point(CMAX, CMAX, CMAX, CMAX, 1'b0);   // dominated, dropped
    send_point(0, 0, 0, 0, 1'b0);               // tie, both kept
    send_point(CMIN, 0, 0, 0, 1'b0);            // evicts both zeros
    send_point(-1, 1, -1, 1, 1'b0);
    send_point(CMAX, CMIN, CMAX, CMIN, 1'b1);
    send_point(CMIN, CMAX, 0, -1, 1'b1);        // single-point set
    send_point(5, 5, 5, 5, 1'b0);
    send_point(5, 5, 5, 4, 1'b0);               // wins on fourth coordinate only
    send_point(5, 5, 5, 6, 1'b0);
    send_point(4, 6, 5, 5, 1'b1);
    send_point(CMIN, CMIN, CMIN, CMIN, 1'b0);
    send_point(CMAX, CMAX, CMAX, CMAX, 1'b1);
    drain_window();

    for (int p = 0; p < 8; p++) begin
      write_dims(dims_plan[p]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 76;
        default: idle_pct = 30;
      endcase
      if (dims_plan[p] == 3'd2) begin
        // fill the window with a two-coordinate antichain, then overflow it
        for (int i = 0; i < WINDOW_DEPTH_DEF; i++)
          send_point(i, 100 - i, rand_coord(), rand_coord(), 1'b0);
        send_point(WINDOW_DEPTH_DEF, 100 - WINDOW_DEPTH_DEF, 0, 0, 1'b0);
        // full window, but this one evicts two entries and gets in
        send_point(0, 99, 0, 0, 1'b0);
        send_point(CMAX, CMAX, CMAX, CMAX, 1'b1);
      end
      send_random_set();
      drain_window();
    end

    drain_window();
    $display("covered %0d points in %0d sets over dims 0..7 with idle gaps and window overflow",
             points_sent, sets_sent);
    $display("checked %0d surviving points", results_checked);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
